// File: rtl/bmh_pkg.sv
// ============================================================================
// bmh_pkg
// Shared types and constants for the bounded max-heap block.
// ============================================================================
package bmh_pkg;

   localparam int DATA_W           = 32;
   localparam int CAP_W            = 7;
   localparam int COUNT_OUT_W      = 7;
   localparam int DEF_MAX_CAPACITY = 64;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // config port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 1;
   localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP,
      ST_DOWN,
      ST_FIN,
      ST_DONE
   } bmh_state_type;

endpackage

// File: rtl/bounded_max_heap_k_smallest.sv
// ============================================================================
// bounded_max_heap_k_smallest
// Keeps the k smallest signed values seen so far in a max-heap in one RAM.
//
// Usage:
//  - req channel: one signed value per item (req_new_value). req_stall is
//    high while an item is being worked on; the block takes one item at a time.
//  - rsp channel: one item per request: the heap root (k-th smallest once
//    full) and the count of values held. The response sits in an output
//    register, so the next request is taken while it waits on rsp_stall.
//  - csr port: capacity k at byte address 0, clamped to 1..MAX_CAPACITY.
//    Write it only while the block is idle.
//  - Work per item: a dropped value goes straight to the done state; an
//    insert or root replacement walks m heap levels, m being at most
//    floor(log2(values held)).
//  - The root is also mirrored in a register so drop decisions need no read.
//  - Reset empties the heap (count to zero) and sets capacity to 64. RAM
//    contents are not cleared; only entries below the count are ever used.
//  - While rsp is stalled a finished item holds in the done state until the
//    output register frees up.
// ============================================================================
module bounded_max_heap_k_smallest #(
   parameter int MAX_CAPACITY = bmh_pkg::DEF_MAX_CAPACITY
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [bmh_pkg::DATA_W-1:0]     req_new_value,
   // response
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [bmh_pkg::DATA_W-1:0]     rsp_largest_kept,
   output logic [bmh_pkg::COUNT_OUT_W-1:0]       rsp_kept_count,
   // config
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [bmh_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [bmh_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [bmh_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);

   localparam int IDX_W = $clog2(MAX_CAPACITY);       // RAM address
   localparam int CNT_W = $clog2(MAX_CAPACITY + 1);   // fill count
   localparam int CH_W  = IDX_W + 2;                  // child index math
   localparam int CMP_W = (CNT_W > bmh_pkg::CAP_W) ? CNT_W : bmh_pkg::CAP_W;
   localparam int DW    = bmh_pkg::DATA_W;

   // ---------------------------------------------------------------------
   // config
   // ---------------------------------------------------------------------
   logic [bmh_pkg::CAP_W-1:0] capacity;

   bmh_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .capacity    (capacity)
   );

   // ---------------------------------------------------------------------
   // heap RAM
   // ---------------------------------------------------------------------
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic signed [DW-1:0]    wr_data;
   logic [IDX_W-1:0]        rd_addr_a;
   logic [IDX_W-1:0]        rd_addr_b;
   logic signed [DW-1:0]    rd_data_a;
   logic signed [DW-1:0]    rd_data_b;

   bmh_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_CAPACITY)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   bmh_pkg::bmh_state_type state_ff, state_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [IDX_W-1:0]       pos_ff, pos_in;       // current hole in the heap
   logic signed [DW-1:0]   val_ff, val_in;       // value being placed
   logic signed [DW-1:0]   root_ff, root_in;     // copy of entry 0
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [DW-1:0]   rsp_value_ff, rsp_value_in;
   logic [bmh_pkg::COUNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bmh_pkg::ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      root_ff      <= root_in;
      rsp_value_ff <= rsp_value_in;
      rsp_count_ff <= rsp_count_in;
   end

   // ---------------------------------------------------------------------
   // decisions shared by the state and datapath blocks
   // ---------------------------------------------------------------------
   logic [CMP_W-1:0] cap_w, k_eff;
   logic             req_fire;
   logic             has_room;      // fill below effective k
   logic             fill_empty;
   logic             beats_root;    // new value strictly below root
   logic             multi;         // more than one entry held
   logic [IDX_W-1:0] fill_idx;
   logic [IDX_W-1:0] fill_parent;
   logic [IDX_W-1:0] pos_parent;
   logic             up_take;       // parent smaller than carried value
   logic [CH_W-1:0]  cnt_ch;
   logic [CH_W-1:0]  left_ch, right_ch;
   logic             right_ok;
   logic             pick_left;
   logic signed [DW-1:0] pick_val;
   logic [IDX_W-1:0] pick_idx;
   logic             dn_take;       // carried value below larger child
   logic [CH_W-1:0]  nleft_ch;
   logic             dn_more;       // chosen child has children of its own
   logic             out_free;

   always_comb begin
      cap_w = CMP_W'(capacity);
      if (cap_w == '0) begin
         k_eff = CMP_W'(1);
      end else if (cap_w > CMP_W'(MAX_CAPACITY)) begin
         k_eff = CMP_W'(MAX_CAPACITY);
      end else begin
         k_eff = cap_w;
      end
   end

   assign req_stall   = (state_ff != bmh_pkg::ST_IDLE);
   assign req_fire    = req_valid && !req_stall;
   assign has_room    = CMP_W'(fill_ff) < k_eff;
   assign fill_empty  = (fill_ff == '0);
   assign beats_root  = req_new_value < root_ff;
   assign multi       = fill_ff > CNT_W'(1);
   assign fill_idx    = IDX_W'(fill_ff);
   assign fill_parent = (fill_idx - IDX_W'(1)) >> 1;
   assign pos_parent  = (pos_ff - IDX_W'(1)) >> 1;
   assign up_take     = rd_data_a < val_ff;

   // sift down: pick left only when strictly larger than right, or when there is no right child
   assign cnt_ch    = CH_W'(fill_ff);
   assign left_ch   = (CH_W'(pos_ff) << 1) + CH_W'(1);
   assign right_ch  = left_ch + CH_W'(1);
   assign right_ok  = right_ch < cnt_ch;
   assign pick_left = !right_ok || (rd_data_a > rd_data_b);
   assign pick_val  = pick_left ? rd_data_a : rd_data_b;
   assign pick_idx  = pick_left ? IDX_W'(left_ch) : IDX_W'(right_ch);
   assign dn_take   = val_ff < pick_val;
   assign nleft_ch  = (CH_W'(pick_idx) << 1) + CH_W'(1);
   assign dn_more   = nleft_ch < cnt_ch;

   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // ---------------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bmh_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (has_room) begin
                  state_in = fill_empty ? bmh_pkg::ST_DONE : bmh_pkg::ST_UP;
               end else if (beats_root && multi) begin
                  state_in = bmh_pkg::ST_DOWN;
               end else begin
                  state_in = bmh_pkg::ST_DONE;
               end
            end
         end
         bmh_pkg::ST_UP: begin
            if (!up_take) begin
               state_in = bmh_pkg::ST_DONE;
            end else if (pos_parent == '0) begin
               state_in = bmh_pkg::ST_FIN;
            end
         end
         bmh_pkg::ST_DOWN: begin
            if (!dn_take) begin
               state_in = bmh_pkg::ST_DONE;
            end else if (!dn_more) begin
               state_in = bmh_pkg::ST_FIN;
            end
         end
         bmh_pkg::ST_FIN: begin
            state_in = bmh_pkg::ST_DONE;
         end
         bmh_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = bmh_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bmh_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // datapath and RAM control
   // The carried value is not written at each level; the hole moves and the
   // value lands once at the end, which gives the same heap as swapping.
   // ---------------------------------------------------------------------
   always_comb begin
      fill_in      = fill_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      root_in      = root_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_count_in = rsp_count_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = val_ff;
      rd_addr_a    = IDX_W'(left_ch);
      rd_addr_b    = IDX_W'(right_ch);

      case (state_ff)
         bmh_pkg::ST_IDLE: begin
            if (req_fire) begin
               val_in = req_new_value;
               if (has_room) begin
                  fill_in = fill_ff + CNT_W'(1);
                  pos_in  = fill_idx;
                  if (fill_empty) begin
                     wr_en   = 1'b1;
                     wr_addr = '0;
                     wr_data = req_new_value;
                     root_in = req_new_value;
                  end else begin
                     rd_addr_a = fill_parent;
                  end
               end else if (beats_root) begin
                  pos_in = '0;
                  if (multi) begin
                     rd_addr_a = IDX_W'(1);
                     rd_addr_b = IDX_W'(2);
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = '0;
                     wr_data = req_new_value;
                     root_in = req_new_value;
                  end
               end
            end
         end
         bmh_pkg::ST_UP: begin
            wr_en = 1'b1;
            if (up_take) begin
               wr_data   = rd_data_a;       // parent moves down into the hole
               pos_in    = pos_parent;
               rd_addr_a = (pos_parent - IDX_W'(1)) >> 1;
            end
         end
         bmh_pkg::ST_DOWN: begin
            wr_en = 1'b1;
            if (dn_take) begin
               wr_data   = pick_val;        // child moves up into the hole
               pos_in    = pick_idx;
               rd_addr_a = IDX_W'(nleft_ch);
               rd_addr_b = IDX_W'(nleft_ch + CH_W'(1));
               if (pos_ff == '0) begin
                  root_in = pick_val;
               end
            end else if (pos_ff == '0) begin
               root_in = val_ff;
            end
         end
         bmh_pkg::ST_FIN: begin
            wr_en = 1'b1;
            if (pos_ff == '0) begin
               root_in = val_ff;
            end
         end
         bmh_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = root_ff;
               rsp_count_in = bmh_pkg::COUNT_OUT_W'(fill_ff);
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_largest_kept = rsp_value_ff;
   assign rsp_kept_count   = rsp_count_ff;

endmodule

// File: rtl/bmh_ram.sv
// ============================================================================
// bmh_ram
// Generic RAM: one write port, two read ports, registered read data.
// ============================================================================
module bmh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// File: rtl/bmh_csr.sv
// ============================================================================
// bmh_csr
// Configuration register file: holds the heap capacity.
// ============================================================================
module bmh_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bmh_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [bmh_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [bmh_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready,
   output logic [bmh_pkg::CAP_W-1:0]           capacity
);

   logic [bmh_pkg::CAP_W-1:0]     capacity_ff;
   logic [bmh_pkg::REG_IDX_W-1:0] reg_idx;
   logic                          wr_hit;

   assign reg_idx = csr_paddr[bmh_pkg::CSR_ADDR_W-1:2];
   assign wr_hit  = csr_psel && csr_penable && csr_pwrite
                    && (reg_idx == bmh_pkg::REG_CAPACITY);

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= bmh_pkg::CAP_RESET;
      end else if (wr_hit) begin
         capacity_ff <= csr_pwdata[bmh_pkg::CAP_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_idx == bmh_pkg::REG_CAPACITY) begin
         csr_prdata = bmh_pkg::CSR_DATA_W'(capacity_ff);
      end
   end

   assign csr_pready = 1'b1;
   assign capacity   = capacity_ff;

endmodule

// File: rtl/bmh_checker.sv
// ============================================================================
// bmh_checker
// Port-level checks for the bounded max-heap block.
// ============================================================================
module bmh_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [bmh_pkg::DATA_W-1:0]     rsp_largest_kept,
   input logic [bmh_pkg::COUNT_OUT_W-1:0]       rsp_kept_count
);

   // every response follows at least one insert
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kept_count != '0))
      else $error("response with empty heap");

   // one item at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous item in flight");

   // a response only appears out of a busy phase
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without work in progress");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_largest_kept)
                                    && $stable(rsp_kept_count)))
      else $error("stalled response changed");

endmodule

bind bounded_max_heap_k_smallest bmh_checker u_bmh_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_largest_kept (rsp_largest_kept),
   .rsp_kept_count   (rsp_kept_count)
);

// File: tb/tb_bounded_max_heap_k_smallest.sv
// ============================================================================
// tb_bounded_max_heap_k_smallest
// Self-checking bench for the bounded max-heap (k smallest values kept).
// A bit-accurate heap predictor runs on every accepted item. The bench writes
// the capacity register between phases, from clamped-low through clamped-high,
// and also lowers it below the held count. Value mixes cover the extremes,
// duplicates, values right at the root and values that force deep sift-downs.
// Handshake pressure runs from none to heavy on both sides, and one phase
// holds the response side off long enough to back up the input channel.
// ============================================================================
module tb_bounded_max_heap_k_smallest;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DATA_W      = bmh_pkg::DATA_W;
   localparam int CAP_W       = bmh_pkg::CAP_W;
   localparam int COUNT_OUT_W = bmh_pkg::COUNT_OUT_W;
   localparam int CSR_ADDR_W  = bmh_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W  = bmh_pkg::CSR_DATA_W;

   localparam int HEAP_DEPTH  = bmh_pkg::DEF_MAX_CAPACITY;
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE      = 16;   // longer than the worst item latency
   localparam int BACKLOG     = 4;    // items staged ahead of the driver
   localparam int LONG_HOLD   = 300;  // cycles the receiver holds off once

   localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   // one result as seen on the rsp channel
   typedef struct packed {
      logic signed [DATA_W-1:0] root;
      logic [COUNT_OUT_W-1:0]   count;
   } heap_view_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic signed [DATA_W-1:0]    req_new_value = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic signed [DATA_W-1:0]    rsp_largest_kept;
   logic [COUNT_OUT_W-1:0]      rsp_kept_count;
   logic                        csr_psel = 1'b0;
   logic                        csr_penable = 1'b0;
   logic                        csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]       csr_paddr = '0;
   logic [CSR_DATA_W-1:0]       csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]       csr_prdata;
   logic                        csr_pready;

   bounded_max_heap_k_smallest dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_new_value    (req_new_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_largest_kept (rsp_largest_kept),
      .rsp_kept_count   (rsp_kept_count),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Heap predictor: own copy of the store, the fill count and capacity.
   // Signed compares throughout, same ordering as the block.
   // ------------------------------------------------------------------------
   logic signed [DATA_W-1:0] heap_q [0:HEAP_DEPTH-1];
   int unsigned              heap_fill = 0;
   logic [CAP_W-1:0]         cap_reg = bmh_pkg::CAP_RESET;

   int n_insert = 0;
   int n_replace = 0;
   int n_drop = 0;
   int n_cap_writes = 0;

   heap_view_type kept_view_q [$];   // expected results, oldest first

   function automatic heap_view_type heap_offer(input logic signed [DATA_W-1:0] v);
      int unsigned k, pos, up, lc, rc, pick;
      logic signed [DATA_W-1:0] t;
      logic walking;
      heap_view_type view;
      // zero acts as 1, anything past the depth as the depth
      k = cap_reg;
      if (k < 1) k = 1;
      if (k > HEAP_DEPTH) k = HEAP_DEPTH;
      if (heap_fill < k) begin
         // append, then sift up while the parent is strictly smaller
         heap_q[heap_fill] = v;
         pos = heap_fill;
         heap_fill++;
         n_insert++;
         walking = 1'b1;
         while (walking && pos > 0) begin
            up = (pos - 1) / 2;
            if (heap_q[up] < heap_q[pos]) begin
               t = heap_q[up]; heap_q[up] = heap_q[pos]; heap_q[pos] = t;
               pos = up;
            end else begin
               walking = 1'b0;
            end
         end
      end else if (v < heap_q[0]) begin
         // full (or over-full after a capacity drop): replace root, sift down
         // across every held entry; ties go to the right child
         heap_q[0] = v;
         pos = 0;
         n_replace++;
         walking = 1'b1;
         while (walking) begin
            lc = 2 * pos + 1;
            rc = lc + 1;
            if (lc >= heap_fill) begin
               walking = 1'b0;
            end else begin
               if (rc >= heap_fill) pick = lc;
               else pick = (heap_q[lc] > heap_q[rc]) ? lc : rc;
               if (heap_q[pos] < heap_q[pick]) begin
                  t = heap_q[pos]; heap_q[pos] = heap_q[pick]; heap_q[pick] = t;
                  pos = pick;
               end else begin
                  walking = 1'b0;
               end
            end
         end
      end else begin
         n_drop++;   // equal to the root is dropped too
      end
      view.root  = (heap_fill == 0) ? '0 : heap_q[0];
      view.count = COUNT_OUT_W'(heap_fill);
      return view;
   endfunction

   // ------------------------------------------------------------------------
   // Edge sampling: accepts and results are taken at the rising edge, before
   // any register in the block updates.
   // ------------------------------------------------------------------------
   int   errors = 0;
   int   offers_pushed = 0;
   int   offers_taken = 0;
   int   results_seen = 0;
   int   cycle_count = 0;
   logic req_taken = 1'b0;

   always @(posedge clock) begin
      heap_view_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending",
                  cycle_count, kept_view_q.size());
         $display("status: fail");
         $finish;
      end else begin
         req_taken = !reset && req_valid && !req_stall;
         if (req_taken) begin
            kept_view_q.push_back(heap_offer(req_new_value));
            offers_taken++;
         end
         if (!reset && rsp_valid && !rsp_stall) begin
            results_seen++;
            if (kept_view_q.size() == 0) begin
               $error("result with nothing expected: largest_kept %0d kept_count %0d",
                      rsp_largest_kept, rsp_kept_count);
               errors++;
            end else begin
               want = kept_view_q.pop_front();
               if (rsp_largest_kept !== want.root) begin
                  $error("largest_kept mismatch: expected %0d actual %0d",
                         want.root, rsp_largest_kept);
                  errors++;
               end
               if (rsp_kept_count !== want.count) begin
                  $error("kept_count mismatch: expected %0d actual %0d",
                         want.count, rsp_kept_count);
                  errors++;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request driver: fed from the staged item queue, changes at the falling
   // edge only once the current item was taken (or nothing is offered).
   // ------------------------------------------------------------------------
   logic signed [DATA_W-1:0] offer_q [$];
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (offer_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid     <= 1'b1;
            req_new_value <= offer_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side: random stalls, plus one long hold-off counted here.
   logic hold_pending = 1'b0;
   int   hold_left = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_pending || hold_left > 0) begin
         if (hold_pending) begin
            hold_left    = LONG_HOLD;
            hold_pending = 1'b0;
         end
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers (all run from the falling edge)
   // ------------------------------------------------------------------------
   task automatic offer(input logic signed [DATA_W-1:0] v);
      while (offer_q.size() >= BACKLOG) @(negedge clock);
      offer_q.push_back(v);
      offers_pushed++;
   endtask

   // every staged item accepted and every result back, then a short pause
   task automatic drain();
      while (offers_taken != offers_pushed || kept_view_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_capacity(input int cap);
      drain();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {bmh_pkg::REG_CAPACITY, 2'b00};
      csr_pwdata  <= CSR_DATA_W'(cap);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      cap_reg = CAP_W'(cap);
      n_cap_writes++;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // idle modes: 0 none, 1 sender sparse, 2 receiver stalls, 3 both light
   task automatic set_idle(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
         default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
   endtask

   // value mix: wide random, tight cluster for duplicates, near the current
   // root (ties and one-off misses), just under the root (forced sift-down),
   // and the range corners
   function automatic logic signed [DATA_W-1:0] next_value();
      int sel;
      logic signed [DATA_W-1:0] root;
      sel  = $urandom_range(99);
      root = (heap_fill > 0) ? heap_q[0] : '0;
      if (sel < 30) return $urandom;
      else if (sel < 50) return DATA_W'($urandom_range(200) - 100);
      else if (sel < 70) return root + DATA_W'($urandom_range(8) - 4);
      else if (sel < 90) return root - DATA_W'($urandom_range(1000, 1));
      else begin
         case ($urandom_range(5))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return VAL_MIN + 1;
            3: return VAL_MAX - 1;
            4: return '0;
            default: return -1;
         endcase
      end
   endfunction

   task automatic random_phase(input int cap, input int n, input int mode,
                               input logic long_hold);
      write_capacity(cap);
      set_idle(mode);
      // sender keeps offering while the receiver sits on its hands
      if (long_hold) hold_pending = 1'b1;
      repeat (n) offer(next_value());
   endtask

   // ------------------------------------------------------------------------
   // Test sequence. The fill count only ever grows (reset is applied once),
   // so capacity climbs first to exercise inserts at every size, then drops
   // below the count to exercise the over-full heap.
   // ------------------------------------------------------------------------
   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // capacity zero acts as one: first value inserts, then root swaps
      write_capacity(0);
      offer(5);
      offer(3);          // smaller than root: replaces it
      offer(3);          // equal to root: dropped
      offer(10);         // larger: dropped
      offer(VAL_MAX);
      offer(VAL_MIN);    // replaces
      offer(VAL_MIN);    // equal, dropped

      // capacity one proper, already full
      write_capacity(1);
      offer(-1);
      offer(0);

      // small heap: ascending inserts climb to the root
      write_capacity(3);
      offer(7);
      offer(100);
      offer(VAL_MAX);    // full now, dropped
      offer(-5);         // replaces, sifts down

      // above the depth clamps to the depth
      write_capacity(127);
      offer(VAL_MAX);
      offer(0);
      offer(-1);
      offer(VAL_MIN + 1);
      offer(VAL_MAX - 1);
      offer(1);

      // random phases across capacities and handshake pressure
      random_phase(8,   150, 0, 1'b0);
      random_phase(16,  150, 1, 1'b0);
      random_phase(33,  200, 2, 1'b0);
      random_phase(64,  300, 0, 1'b1);   // long response hold-off here
      random_phase(127, 250, 3, 1'b0);
      random_phase(2,   200, 2, 1'b0);   // far below the held count
      random_phase(1,   150, 1, 1'b0);
      random_phase(50,  200, 3, 1'b0);
      random_phase(0,   100, 0, 1'b0);
      random_phase(64,  300, 3, 1'b0);
      drain();

      $display("run covered %0d items: %0d inserts, %0d root replacements, %0d drops",
               offers_taken, n_insert, n_replace, n_drop);
      $display("%0d capacity writes (0 to 127), %0d results checked, %0d errors",
               n_cap_writes, results_seen, errors);
      if (errors == 0 && kept_view_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
